// ===== rtl/core/fjip_pkg.sv =====
// ---------------------------------------------------------------------------
// fjip_pkg
// Shared types, event codes and key tables for the floppy image text parser.
// ---------------------------------------------------------------------------
package fjip_pkg;

    // Fill bound for the data word index
    localparam int MAX_SECTOR_WORDS = 4096;
    localparam int WORD_CAP_INT     = (MAX_SECTOR_WORDS - 1 > 4095) ? 4095
                                                                    : MAX_SECTOR_WORDS - 1;
    localparam logic [11:0] WORD_CAP = WORD_CAP_INT[11:0];

    // Event codes
    localparam logic [2:0] EV_SECTOR_ID = 3'd0;
    localparam logic [2:0] EV_LENGTH    = 3'd1;
    localparam logic [2:0] EV_PATTERN   = 3'd2;
    localparam logic [2:0] EV_DATA_WORD = 3'd3;
    localparam logic [2:0] EV_SECT_DONE = 3'd4;
    localparam logic [2:0] EV_SIDE_DONE = 3'd5;
    localparam logic [2:0] EV_FINISHED  = 3'd6;
    localparam logic [2:0] EV_ERROR     = 3'd7;

    // Characters of the syntax
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Key candidate masks
    localparam logic [3:0] KEY_ALL  = 4'hF;
    localparam logic [3:0] KEY_DATA = 4'h8;

    // Number flag bits
    localparam int FL_NEG     = 0;
    localparam int FL_STARTED = 1;
    localparam int FL_STOP    = 2;
    localparam int FL_TOKEN   = 3;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  track_num;
        logic [7:0]  side_num;
        logic [7:0]  sector_slot;
        logic [31:0] value_word;
        logic [11:0] word_position;
        logic        last_of_run;
    } out_item_t;

    // Key spelling: sector, length, pattern, data
    function automatic logic [7:0] key_char(input logic [1:0] k, input logic [2:0] pos);
        logic [55:0] txt;
        case (k)
            2'd0:    txt = 56'h73_65_63_74_6F_72_00; // sector
            2'd1:    txt = 56'h6C_65_6E_67_74_68_00; // length
            2'd2:    txt = 56'h70_61_74_74_65_72_6E; // pattern
            default: txt = 56'h64_61_74_61_00_00_00; // data
        endcase
        case (pos)
            3'd0:    key_char = txt[55:48];
            3'd1:    key_char = txt[47:40];
            3'd2:    key_char = txt[39:32];
            3'd3:    key_char = txt[31:24];
            3'd4:    key_char = txt[23:16];
            3'd5:    key_char = txt[15:8];
            3'd6:    key_char = txt[7:0];
            default: key_char = 8'h00;
        endcase
    endfunction

    function automatic logic [5:0] key_len(input logic [1:0] k);
        case (k)
            2'd0:    key_len = 6'd6;
            2'd1:    key_len = 6'd6;
            2'd2:    key_len = 6'd7;
            default: key_len = 6'd4;
        endcase
    endfunction

    function automatic out_item_t make_ev(
        input logic [2:0]  kind,
        input logic [7:0]  trk,
        input logic [7:0]  sd,
        input logic [7:0]  slot,
        input logic [31:0] value,
        input logic [11:0] wpos
    );
        out_item_t r;
        r.event_kind    = kind;
        r.track_num     = trk;
        r.side_num      = sd;
        r.sector_slot   = slot;
        r.value_word    = value;
        r.word_position = wpos;
        r.last_of_run   = 1'b0;
        make_ev = r;
    endfunction

endpackage

// ===== rtl/core/floppy_json_image_parser.sv =====
// ---------------------------------------------------------------------------
// floppy_json_image_parser
// Streaming parser for a floppy image JSON text: tracks nesting, sector keys and
// decimal values, and reports one event per known value, word, boundary or error.
// ---------------------------------------------------------------------------
//
//  Channel   Ports                          Direction  Carries
//  s_        s_valid s_ready s_payload      in         one text byte or end mark
//  m_        m_valid m_ready m_payload      out        one parse event
//
//  A byte is registered in the input stage at its transfer and parsed there
//  once the queue has room; its events are then registered into the queue.
//  One byte per cycle is sustained while m_ready is high and each byte
//  yields at most one event; the four-entry event queue drains one event
//  per cycle while m_ready is high, and two or three events of one byte
//  hold s_ready low until at most one is queued. s_ready depends only on
//  registered state, never on m_ready. aresetn (synchronous, active low)
//  clears the parse state and empties the input stage and the event queue.
//
module floppy_json_image_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fjip_pkg::in_item_t  s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output fjip_pkg::out_item_t m_payload
);
    import fjip_pkg::*;

    // Parse phases
    localparam logic [3:0] PH_LEVEL    = 4'd0;
    localparam logic [3:0] PH_OBJ      = 4'd1;
    localparam logic [3:0] PH_KEY_OPEN = 4'd2;
    localparam logic [3:0] PH_KEY      = 4'd3;
    localparam logic [3:0] PH_COLON    = 4'd4;
    localparam logic [3:0] PH_VALUE    = 4'd5;
    localparam logic [3:0] PH_BRACKET  = 4'd6;
    localparam logic [3:0] PH_SECT_END = 4'd7;
    localparam logic [3:0] PH_SIDE_END = 4'd8;
    localparam logic [3:0] PH_TRK_END  = 4'd9;
    localparam logic [3:0] PH_DONE     = 4'd10;

    localparam int QDEPTH = 4;

    // Input stage
    logic     in_valid_reg;
    in_item_t in_data_reg;

    // Parse state
    logic [3:0]  phase_reg,  phase_next;
    logic [1:0]  nest_reg,   nest_next;
    logic [7:0]  track_reg,  track_next;
    logic [7:0]  side_reg,   side_next;
    logic [7:0]  slot_reg,   slot_next;
    logic [3:0]  cand_reg,   cand_next;
    logic [5:0]  kpos_reg,   kpos_next;
    logic [31:0] accum_reg,  accum_next;
    logic [3:0]  flags_reg,  flags_next;
    logic [11:0] wcnt_reg,   wcnt_next;

    // Events of the byte in the input stage
    out_item_t   res_arr [0:2];
    logic [1:0]  res_n;

    // Event queue: entry 0 drives m_
    out_item_t   q_reg  [0:QDEPTH-1];
    out_item_t   q_next [0:QDEPTH-1];
    logic [2:0]  q_cnt_reg, q_cnt_next;
    logic [2:0]  q_base;

    logic        adv;
    logic        pop;
    logic [7:0]  c;
    logic [31:0] num_val;
    logic [35:0] fed;
    logic [3:0]  match;

    // Room for three events once at most one is queued
    assign adv     = in_valid_reg && (q_cnt_reg <= 3'd1);
    assign s_ready = !in_valid_reg || (q_cnt_reg <= 3'd1);
    assign pop     = m_valid && m_ready;

    assign m_valid   = (q_cnt_reg != 3'd0);
    assign m_payload = q_reg[0];

    assign c       = in_data_reg.char_byte;
    assign num_val = flags_reg[FL_NEG] ? (32'd0 - accum_reg) : accum_reg;

    // One character of a decimal value: returns {flags, accum}
    function automatic logic [35:0] num_feed(
        input logic [7:0]  ch,
        input logic [31:0] acc,
        input logic [3:0]  fl
    );
        logic [31:0] a;
        logic [3:0]  f;
        logic        digit;
        a     = acc;
        f     = fl;
        digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        f[FL_TOKEN] = 1'b1;
        if (!f[FL_STOP]) begin
            if (!f[FL_STARTED]) begin
                if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
                    // skip leading whitespace
                end else if (ch == CH_MINUS) begin
                    f[FL_NEG]     = 1'b1;
                    f[FL_STARTED] = 1'b1;
                end else if (ch == CH_PLUS) begin
                    f[FL_STARTED] = 1'b1;
                end else if (digit) begin
                    a             = {28'd0, ch[3:0]};
                    f[FL_STARTED] = 1'b1;
                end else begin
                    f[FL_STOP] = 1'b1;
                end
            end else if (digit) begin
                a = (acc << 3) + (acc << 1) + {28'd0, ch[3:0]};
            end else begin
                f[FL_STOP] = 1'b1;
            end
        end
        num_feed = {f, a};
    endfunction

    assign fed = num_feed(c, accum_reg, flags_reg);

    // Key resolution at the closing quote; a later key wins as in the table order
    always_comb begin
        match = 4'd0;
        for (int k = 0; k < 4; k++) begin
            if (cand_reg[k] && (kpos_reg == key_len(k[1:0]))) begin
                match = 4'd1 << k;
            end
        end
    end

    // Parse one byte
    always_comb begin
        phase_next = phase_reg;
        nest_next  = nest_reg;
        track_next = track_reg;
        side_next  = side_reg;
        slot_next  = slot_reg;
        cand_next  = cand_reg;
        kpos_next  = kpos_reg;
        accum_next = accum_reg;
        flags_next = flags_reg;
        wcnt_next  = wcnt_reg;
        res_n      = 2'd0;
        for (int i = 0; i < 3; i++) begin
            res_arr[i] = '0;
        end

        if (phase_reg < PH_DONE) begin
            if (in_data_reg.end_of_input) begin
                res_arr[res_n] = make_ev(EV_FINISHED, track_reg, side_reg, slot_reg,
                                         32'd0, 12'd0);
                res_n      = res_n + 2'd1;
                phase_next = PH_DONE;
            end else begin
                unique case (phase_reg) inside
                    PH_LEVEL: begin
                        slot_next = 8'd0;
                        if (c != CH_LBRACK) begin
                            res_arr[0] = make_ev(EV_ERROR, track_reg, side_reg, 8'd0,
                                                 {24'd0, c}, 12'd0);
                            res_arr[1] = make_ev(EV_FINISHED, track_reg, side_reg, 8'd0,
                                                 32'd0, 12'd0);
                            res_n      = 2'd2;
                            phase_next = PH_DONE;
                        end else begin
                            nest_next = nest_reg + 2'd1;
                            if (nest_next == 2'd3) begin
                                phase_next = PH_OBJ;
                            end
                        end
                    end
                    PH_OBJ, PH_KEY_OPEN, PH_COLON: begin
                        if ((phase_reg == PH_OBJ && c != CH_LBRACE) ||
                            (phase_reg == PH_KEY_OPEN && c != CH_QUOTE) ||
                            (phase_reg == PH_COLON && c != CH_COLON)) begin
                            res_arr[0] = make_ev(EV_ERROR, track_reg, side_reg, slot_reg,
                                                 {24'd0, c}, 12'd0);
                            res_arr[1] = make_ev(EV_FINISHED, track_reg, side_reg, slot_reg,
                                                 32'd0, 12'd0);
                            res_n      = 2'd2;
                            phase_next = PH_DONE;
                        end else if (phase_reg == PH_OBJ) begin
                            phase_next = PH_KEY_OPEN;
                        end else if (phase_reg == PH_KEY_OPEN) begin
                            cand_next  = KEY_ALL;
                            kpos_next  = 6'd0;
                            phase_next = PH_KEY;
                        end else begin
                            accum_next = 32'd0;
                            flags_next = 4'd0;
                            wcnt_next  = 12'd0;
                            phase_next = PH_VALUE;
                        end
                    end
                    PH_KEY: begin
                        if (c == CH_QUOTE) begin
                            cand_next  = match;
                            phase_next = PH_COLON;
                        end else begin
                            for (int k = 0; k < 4; k++) begin
                                if ((kpos_reg >= key_len(k[1:0])) ||
                                    (key_char(k[1:0], kpos_reg[2:0]) != c)) begin
                                    cand_next[k] = 1'b0;
                                end
                            end
                            if (kpos_reg != 6'd63) begin
                                kpos_next = kpos_reg + 6'd1;
                            end
                        end
                    end
                    PH_VALUE: begin
                        if (c == CH_COMMA || c == CH_RBRACE) begin
                            // close the value; only a known key yields an event
                            if (cand_reg == KEY_DATA) begin
                                if (flags_reg[FL_TOKEN]) begin
                                    res_arr[0] = make_ev(EV_DATA_WORD, track_reg, side_reg,
                                                         slot_reg, num_val, wcnt_reg);
                                    res_n      = 2'd1;
                                    if (wcnt_reg < WORD_CAP) begin
                                        wcnt_next = wcnt_reg + 12'd1;
                                    end
                                end
                            end else if (cand_reg == 4'd1 || cand_reg == 4'd2 ||
                                         cand_reg == 4'd4) begin
                                res_arr[0] = make_ev((cand_reg == 4'd1) ? EV_SECTOR_ID :
                                                     (cand_reg == 4'd2) ? EV_LENGTH :
                                                     EV_PATTERN,
                                                     track_reg, side_reg, slot_reg,
                                                     num_val, 12'd0);
                                res_n      = 2'd1;
                            end
                            phase_next = (c == CH_RBRACE) ? PH_SECT_END : PH_KEY_OPEN;
                        end else if (c == CH_LBRACK) begin
                            phase_next = PH_BRACKET;
                        end else begin
                            flags_next = fed[35:32];
                            accum_next = fed[31:0];
                        end
                    end
                    PH_BRACKET: begin
                        if (c == CH_RBRACK) begin
                            phase_next = PH_VALUE;
                        end else if (c == CH_COMMA && cand_reg == KEY_DATA) begin
                            res_arr[0] = make_ev(EV_DATA_WORD, track_reg, side_reg, slot_reg,
                                                 num_val, wcnt_reg);
                            res_n      = 2'd1;
                            if (wcnt_reg < WORD_CAP) begin
                                wcnt_next = wcnt_reg + 12'd1;
                            end
                            accum_next = 32'd0;
                            flags_next = 4'd0;
                        end else begin
                            flags_next = fed[35:32];
                            accum_next = fed[31:0];
                        end
                    end
                    PH_SECT_END: begin
                        res_arr[0] = make_ev(EV_SECT_DONE, track_reg, side_reg, slot_reg,
                                             32'd0, 12'd0);
                        res_n      = 2'd1;
                        if (c == CH_COMMA) begin
                            slot_next  = slot_reg + 8'd1;
                            phase_next = PH_OBJ;
                        end else if (c == CH_RBRACK) begin
                            nest_next = nest_reg - 2'd1;
                            if (nest_next == 2'd0) begin
                                res_arr[1] = make_ev(EV_FINISHED, track_reg, side_reg,
                                                     slot_reg, 32'd0, 12'd0);
                                res_n      = 2'd2;
                                phase_next = PH_DONE;
                            end else begin
                                phase_next = PH_SIDE_END;
                            end
                        end else begin
                            res_arr[1] = make_ev(EV_ERROR, track_reg, side_reg, slot_reg,
                                                 {24'd0, c}, 12'd0);
                            res_arr[2] = make_ev(EV_FINISHED, track_reg, side_reg, slot_reg,
                                                 32'd0, 12'd0);
                            res_n      = 2'd3;
                            phase_next = PH_DONE;
                        end
                    end
                    PH_SIDE_END: begin
                        res_arr[0] = make_ev(EV_SIDE_DONE, track_reg, side_reg, slot_reg,
                                             {24'd0, slot_reg} + 32'd1, 12'd0);
                        res_n      = 2'd1;
                        side_next  = side_reg + 8'd1;
                        if (c == CH_COMMA) begin
                            phase_next = PH_LEVEL;
                        end else if (c == CH_RBRACK) begin
                            nest_next = nest_reg - 2'd1;
                            if (nest_next == 2'd0) begin
                                res_arr[1] = make_ev(EV_FINISHED, track_reg, side_next,
                                                     slot_reg, 32'd0, 12'd0);
                                res_n      = 2'd2;
                                phase_next = PH_DONE;
                            end else begin
                                phase_next = PH_TRK_END;
                            end
                        end else begin
                            res_arr[1] = make_ev(EV_ERROR, track_reg, side_reg, slot_reg,
                                                 {24'd0, c}, 12'd0);
                            res_arr[2] = make_ev(EV_FINISHED, track_reg, side_next,
                                                 slot_reg, 32'd0, 12'd0);
                            res_n      = 2'd3;
                            phase_next = PH_DONE;
                        end
                    end
                    default: begin
                        // track end: the byte after a track's closing bracket
                        track_next = track_reg + 8'd1;
                        if (c == CH_COMMA) begin
                            side_next  = 8'd0;
                            phase_next = PH_LEVEL;
                        end else if (c == CH_RBRACK) begin
                            nest_next  = nest_reg - 2'd1;
                            res_arr[0] = make_ev(EV_FINISHED, track_next, side_reg,
                                                 slot_reg, 32'd0, 12'd0);
                            res_n      = 2'd1;
                            phase_next = PH_DONE;
                        end else begin
                            res_arr[0] = make_ev(EV_ERROR, track_reg, side_reg, slot_reg,
                                                 {24'd0, c}, 12'd0);
                            res_arr[1] = make_ev(EV_FINISHED, track_next, side_reg,
                                                 slot_reg, 32'd0, 12'd0);
                            res_n      = 2'd2;
                            phase_next = PH_DONE;
                        end
                    end
                endcase
            end
        end

        // mark the final event of this byte
        for (int i = 0; i < 3; i++) begin
            res_arr[i].last_of_run = (i[1:0] == res_n - 2'd1) && (res_n != 2'd0);
        end
    end

    // Queue: shift out on transfer, append this byte's events behind what stays
    assign q_base = q_cnt_reg - {2'd0, pop};

    always_comb begin
        for (int i = 0; i < QDEPTH; i++) begin
            if (pop && i < QDEPTH - 1) begin
                q_next[i] = q_reg[i + 1];
            end else begin
                q_next[i] = q_reg[i];
            end
            for (int j = 0; j < 3; j++) begin
                if (adv && (j[1:0] < res_n) && (q_base + j[2:0] == i[2:0])) begin
                    q_next[i] = res_arr[j];
                end
            end
        end
        q_cnt_next = q_base + (adv ? {1'b0, res_n} : 3'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            q_cnt_reg    <= 3'd0;
            phase_reg    <= PH_LEVEL;
            nest_reg     <= 2'd0;
            track_reg    <= 8'd0;
            side_reg     <= 8'd0;
            slot_reg     <= 8'd0;
            cand_reg     <= KEY_ALL;
            kpos_reg     <= 6'd0;
            accum_reg    <= 32'd0;
            flags_reg    <= 4'd0;
            wcnt_reg     <= 12'd0;
        end else begin
            // hold the input stage until the queue has room
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            q_cnt_reg <= q_cnt_next;
            if (adv) begin
                phase_reg <= phase_next;
                nest_reg  <= nest_next;
                track_reg <= track_next;
                side_reg  <= side_next;
                slot_reg  <= slot_next;
                cand_reg  <= cand_next;
                kpos_reg  <= kpos_next;
                accum_reg <= accum_next;
                flags_reg <= flags_next;
                wcnt_reg  <= wcnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_payload;
        end
        for (int i = 0; i < QDEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

`ifndef SYNTH
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_cnt_reg <= 3'd4)
        else $error("event queue overflow");

    a_silent_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && phase_reg >= PH_DONE) |-> (res_n == 2'd0))
        else $error("event after the parse finished");

    a_last_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && res_n != 2'd0) |-> res_arr[res_n - 2'd1].last_of_run)
        else $error("final event of a byte not marked");

    a_finish_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && res_n != 2'd0 && res_arr[res_n - 2'd1].event_kind == EV_FINISHED)
        |=> (phase_reg == PH_DONE))
        else $error("finished event without stopping the parse");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !in_valid_reg))
        else $error("queue not empty after reset");
`endif

endmodule
